>>> rtl/erwa_pkg.sv
// Package for the encoder rate weighted average unit.
// Holds widths, constants and the structs shared by all rtl/erwa_* modules.
// No dependencies.
package erwa_pkg;

   localparam int HISTORY_DEPTH = 20;

   localparam int PERIOD_W = 20;
   localparam int TIME_W   = 32;
   localparam int RATE_W   = 24;

   localparam logic [RATE_W-1:0]   RATE_MAX        = '1;
   localparam logic [PERIOD_W-1:0] THRESHOLD_RESET = PERIOD_W'(500000);

   localparam int RATE_NUMERATOR = 60000000;
   localparam int RATE_NUM_W     = $clog2(RATE_NUMERATOR + 1);

   localparam int WEIGHT_SUM = HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2;
   localparam int TOTAL_W    = RATE_W + $clog2(HISTORY_DEPTH);
   localparam int SUM_W      = RATE_W + $clog2(WEIGHT_SUM);
   localparam int MULT_W     = RATE_W + $clog2(HISTORY_DEPTH + 1);
   localparam int DIV_W      = (SUM_W > TIME_W) ? SUM_W : TIME_W;
   localparam int STEP_W     = $clog2(DIV_W + 1);

   localparam logic [DIV_W-1:0] RATE_DIVIDEND =
      DIV_W'(RATE_NUMERATOR) << (DIV_W - RATE_NUM_W);

   // floor(sum / WEIGHT_SUM) as (sum * AVG_RECIP) >> AVG_SHIFT, exact for any SUM_W-bit sum
   localparam int AVG_SHIFT  = SUM_W + $clog2(WEIGHT_SUM);
   localparam int RECIP_W    = SUM_W + 1;
   localparam int AVG_PROD_W = SUM_W + RECIP_W;
   localparam longint unsigned AVG_RECIP_FULL =
      ((64'd1 << AVG_SHIFT) + 64'(WEIGHT_SUM) - 64'd1) / 64'(WEIGHT_SUM);
   localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(AVG_RECIP_FULL);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int REQ_DATA_W = ((PERIOD_W + TIME_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * RATE_W + 7) / 8) * 8;

   typedef struct packed {
      logic              pulse_hit;
      logic [TIME_W-1:0] elapsed;
   } erwa_task_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DIV_W-1:0]  divisor;
      logic [STEP_W-1:0] steps;
   } erwa_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } erwa_div_rsp_type;

endpackage

>>> rtl/erwa_front.sv
// Front end: threshold register, edge detection and elapsed-time capture.
// Pushes one task per accepted item into erwa_queue. Uses erwa_pkg.
module erwa_front
   import erwa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [PERIOD_W-1:0]   csr_data,
   input  logic                  queue_full,
   output logic                  push,
   output erwa_task_type         push_task
);

   logic [PERIOD_W-1:0] thresh_ff, thresh_in;
   logic                above_ff, above_in;
   logic [TIME_W-1:0]   last_ff, last_in;
   logic [PERIOD_W-1:0] period;
   logic [TIME_W-1:0]   stamp;
   logic                below;
   logic                hit;

   assign req_tready = ~queue_full;
   assign csr_ready  = 1'b1;
   assign period     = req_tdata[PERIOD_W-1:0];
   assign stamp      = req_tdata[PERIOD_W +: TIME_W];
   assign below      = (period <= thresh_ff);
   assign hit        = below & above_ff;
   assign push       = req_tvalid & req_tready;

   assign push_task.pulse_hit = hit;
   assign push_task.elapsed   = stamp - last_ff;

   always_comb begin
      thresh_in = thresh_ff;
      above_in  = above_ff;
      last_in   = last_ff;
      if (csr_valid & csr_ready) begin
         thresh_in = csr_data;
      end
      if (push) begin
         above_in = ~below;
         if (hit) begin
            last_in = stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESHOLD_RESET;
         above_ff  <= 1'b0;
         last_ff   <= '0;
      end else begin
         thresh_ff <= thresh_in;
         above_ff  <= above_in;
         last_ff   <= last_in;
      end
   end

endmodule

>>> rtl/erwa_queue.sv
// Short task queue between front and back end.
// Depth set by QUEUE_DEPTH in erwa_pkg.
module erwa_queue
   import erwa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  erwa_task_type push_task,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output erwa_task_type head_task
);

   erwa_task_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_task  = slot_ff[rd_ff];

   function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] ptr);
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = bump(wr_ff);
      end
      if (pop) begin
         rd_in = bump(rd_ff);
      end
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_task;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/erwa_divider.sv
// Restoring divider, one quotient bit per cycle, used by the back end.
// Takes a left-aligned dividend and a step count. Uses erwa_pkg.
module erwa_divider
   import erwa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  erwa_div_req_type req,
   output erwa_div_rsp_type rsp
);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    shifted;
   logic [DIV_W:0]    diff;

   assign shifted      = {rem_ff, quo_ff[DIV_W-1]};
   assign diff         = shifted - {1'b0, dvs_ff};
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         dvs_in = req.divisor;
         cnt_in = req.steps;
      end else if (cnt_ff != '0) begin
         if (diff[DIV_W]) begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end else begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

endmodule

>>> rtl/erwa_back.sv
// Back end: rate division, history shift line, running weighted sum, average
// by reciprocal multiplication and the result register. Uses erwa_pkg and erwa_divider.
module erwa_back
   import erwa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  erwa_task_type         head_task,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_RATE   = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_AVG    = 5'b01000,
      ST_OUT    = 5'b10000
   } erwa_state_type;

   erwa_state_type      state_ff, state_in;
   logic [RATE_W-1:0]   hist_ff [HISTORY_DEPTH];
   logic [RATE_W-1:0]   hist_in [HISTORY_DEPTH];
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [RATE_W-1:0]   instant_ff, instant_in;
   logic [RATE_W-1:0]   filtered_ff, filtered_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_user_ff, rsp_user_in;
   logic [MULT_W-1:0]   scaled;
   logic [SUM_W:0]      sum_wide;
   logic [AVG_PROD_W-1:0] avg_prod;
   logic                load_out;
   erwa_div_req_type    div_req;
   erwa_div_rsp_type    div_rsp;

   erwa_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign scaled   = MULT_W'(instant_ff) * MULT_W'(HISTORY_DEPTH);
   assign sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(scaled) - (SUM_W+1)'(total_ff);
   assign avg_prod = AVG_PROD_W'(sum_ff) * AVG_PROD_W'(AVG_RECIP);
   assign load_out = (state_ff == ST_OUT) & (~rsp_valid_ff | rsp_tready);
   assign pop      = load_out;

   always_comb begin
      hist_in[0] = instant_ff;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
         hist_in[i] = hist_ff[i-1];
      end
   end

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      sum_in       = sum_ff;
      instant_in   = instant_ff;
      filtered_in  = filtered_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      div_req      = '{start: 1'b0, dividend: RATE_DIVIDEND,
                       divisor: DIV_W'(head_task.elapsed), steps: STEP_W'(RATE_NUM_W)};
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head_task.pulse_hit) begin
                  div_req.start = 1'b1;
                  state_in      = ST_RATE;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_RATE: begin
            if (div_rsp.done) begin
               if ((head_task.elapsed == '0) || (div_rsp.quotient[DIV_W-1:RATE_W] != '0)) begin
                  instant_in = RATE_MAX;
               end else begin
                  instant_in = div_rsp.quotient[RATE_W-1:0];
               end
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            total_in = total_ff + TOTAL_W'(instant_ff) - TOTAL_W'(hist_ff[HISTORY_DEPTH-1]);
            sum_in   = sum_wide[SUM_W-1:0];
            state_in = ST_AVG;
         end
         ST_AVG: begin
            filtered_in = avg_prod[AVG_SHIFT +: RATE_W];
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({filtered_ff, instant_ff});
               rsp_user_in  = head_task.pulse_hit;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         sum_ff       <= '0;
         instant_ff   <= '0;
         filtered_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         sum_ff       <= sum_in;
         instant_ff   <= instant_in;
         filtered_ff  <= filtered_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_UPDATE) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               hist_ff[i] <= hist_in[i];
            end
         end
      end
   end

endmodule

>>> rtl/encoder_rate_weighted_average_unit.sv
// Top level of the encoder rate weighted average unit.
// Depends on erwa_pkg, erwa_front, erwa_queue and erwa_back.
//
// Usage:
//   req channel: one item per sample tick, tdata = semi-period (20 bits) and
//   microsecond timestamp (32 bits). rsp channel: exactly one item per
//   request, tdata = instant rate and filtered rate, tuser = updated flag.
//   csr channel: writes the 20-bit period threshold; always ready. Write it
//   only while no request is in flight.
// Sequencing:
//   A tick without a rate update passes from the task queue through the back
//   end's idle and output states into the output register. A tick that
//   computes a rate runs the one-bit-per-cycle divider once (26 steps),
//   updates the running weighted sum, forms the average by a reciprocal
//   multiply and then loads the output register. The back end works on one
//   task at a time and pops it only when it loads the result.
// Reset:
//   Synchronous, active high. Clears the history, the running sums, the held
//   rates, the edge flag and the last computation time; threshold = 500000.
// Backpressure:
//   A result waits in the output register while rsp_tready is low; the task
//   queue keeps taking requests until its two slots fill, then req_tready drops.
module encoder_rate_weighted_average_unit
   import erwa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // semi_period_us, timestamp_us
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // instant_rate, filtered_rate
   output logic                  rsp_tuser,   // updated
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [PERIOD_W-1:0]   csr_data     // period_threshold_us
);

   logic          push;
   erwa_task_type push_task;
   logic          queue_full;
   logic          pop;
   logic          head_valid;
   erwa_task_type head_task;

   erwa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push),
      .push_task  (push_task)
   );

   erwa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_task  (push_task),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_task  (head_task)
   );

   erwa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_task  (head_task),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> rtl/erwa_checker.sv
// Port-level checker for encoder_rate_weighted_average_unit, with its bind.
// Uses erwa_pkg.
module erwa_checker
   import erwa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   logic [RSP_DATA_W-1:0] last_data_ff, last_data_in;
   logic [2:0]            pending_ff, pending_in;
   logic                  req_fire;
   logic                  rsp_fire;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   always_comb begin
      last_data_in = rsp_fire ? rsp_tdata : last_data_ff;
      pending_in   = pending_ff + 3'(req_fire) - 3'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_data_ff <= '0;
         pending_ff   <= '0;
      end else begin
         last_data_ff <= last_data_in;
         pending_ff   <= pending_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_no_update_repeats: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_tuser |-> rsp_tdata == last_data_ff)
      else $error("result without update does not repeat held rates");

   a_no_extra_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 3'd0)
      else $error("result without a pending request");

endmodule

bind encoder_rate_weighted_average_unit erwa_checker u_checker (.*);

>>> tb/encoder_rate_weighted_average_unit_tb.sv
// Testbench for encoder_rate_weighted_average_unit: drives sample ticks and threshold writes,
// predicts every result in a scoreboard class and checks it field by field.
// Depends on erwa_pkg and the unit's rtl.
`timescale 1ns / 100ps

module encoder_rate_weighted_average_unit_tb;
   import erwa_pkg::*;

   localparam int unsigned STALL_LIMIT = 4000;
   localparam logic [PERIOD_W-1:0] PERIOD_ALL_ONES = '1;

   typedef struct packed {
      logic [RATE_W-1:0] instant;
      logic [RATE_W-1:0] filtered;
      logic              updated;
   } rate_result_type;

   class rate_scoreboard_type;
      logic [PERIOD_W-1:0] threshold;
      bit                  armed;
      logic [TIME_W-1:0]   last_time;
      logic [RATE_W-1:0]   history [HISTORY_DEPTH];
      logic [RATE_W-1:0]   held_instant;
      logic [RATE_W-1:0]   held_filtered;
      rate_result_type     expected_q [$];
      int unsigned         failures;

      function new();
         threshold     = THRESHOLD_RESET;
         armed         = 1'b0;
         last_time     = '0;
         held_instant  = '0;
         held_filtered = '0;
         failures      = 0;
         foreach (history[i]) history[i] = '0;
      endfunction

      function void write_threshold(logic [PERIOD_W-1:0] value);
         threshold = value;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_tick(logic [PERIOD_W-1:0] period, logic [TIME_W-1:0] stamp);
         logic [TIME_W-1:0] elapsed;
         longint unsigned   quotient;
         longint unsigned   acc;
         rate_result_type   res;
         res.updated = 1'b0;
         if (period <= threshold) begin
            if (armed) begin
               elapsed = stamp - last_time;
               if (elapsed == '0) begin
                  held_instant = RATE_MAX;
               end else begin
                  quotient = longint'(RATE_NUMERATOR) / longint'(elapsed);
                  held_instant = (quotient > longint'(RATE_MAX)) ? RATE_MAX
                                                                 : RATE_W'(quotient);
               end
               last_time = stamp;
               for (int i = HISTORY_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
               history[0] = held_instant;
               acc = 0;
               for (int i = 0; i < HISTORY_DEPTH; i++)
                  acc += longint'(history[i]) * longint'(HISTORY_DEPTH - i);
               held_filtered = RATE_W'(acc / longint'(WEIGHT_SUM));
               res.updated = 1'b1;
            end
            armed = 1'b0;
         end else begin
            armed = 1'b1;
         end
         res.instant  = held_instant;
         res.filtered = held_filtered;
         expected_q.push_back(res);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data, logic flag);
         rate_result_type exp_res;
         if (expected_q.size() == 0) begin
            $error("result item arrived with no tick pending");
            failures++;
            return;
         end
         exp_res = expected_q.pop_front();
         if (data[RATE_W-1:0] !== exp_res.instant) begin
            $error("instant_rate: expected %0d, actual %0d", exp_res.instant,
                   data[RATE_W-1:0]);
            failures++;
         end
         if (data[2*RATE_W-1:RATE_W] !== exp_res.filtered) begin
            $error("filtered_rate: expected %0d, actual %0d", exp_res.filtered,
                   data[2*RATE_W-1:RATE_W]);
            failures++;
         end
         if (flag !== exp_res.updated) begin
            $error("updated: expected %0d, actual %0d", exp_res.updated, flag);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // semi_period_us, timestamp_us
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // instant_rate, filtered_rate
   logic                  rsp_tuser;   // updated
   logic                  csr_valid;
   logic                  csr_ready;
   logic [PERIOD_W-1:0]   csr_data;    // period_threshold_us

   rate_scoreboard_type sb = new();
   logic [PERIOD_W-1:0] cur_thr;
   logic [TIME_W-1:0]   now_us;
   bit                  req_steady;
   bit                  rsp_steady;
   int unsigned         rsp_hold;
   int unsigned         idle_cycles = 0;

   encoder_rate_weighted_average_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [TIME_W-1:0] pick_delta();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 3)  return '0;
      if (r < 18) return $urandom_range(1, 8);
      if (r < 58) return $urandom_range(9, 2000);
      if (r < 88) return $urandom_range(2001, 2000000);
      if (r < 98) return $urandom_range(2000001, 60000000);
      return $urandom();
   endfunction

   function automatic logic [PERIOD_W-1:0] period_above();
      if (cur_thr == PERIOD_ALL_ONES) return PERIOD_W'($urandom_range(0, 'hFFFFF));
      if ($urandom_range(0, 1) == 0) return cur_thr + 1'b1;
      return PERIOD_W'($urandom_range('hFFFFF, cur_thr + 1));
   endfunction

   function automatic logic [PERIOD_W-1:0] period_below();
      int unsigned r;
      r = $urandom_range(0, 3);
      if (r == 0) return cur_thr;
      if (r == 1) return '0;
      return PERIOD_W'($urandom_range(cur_thr, 0));
   endfunction

   // rsp side backpressure
   initial begin
      rsp_tready = 1'b0;
      rsp_hold   = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!rsp_steady && $urandom_range(0, 2) == 0) rsp_hold = pick_gap();
         end
      end
   end

   // observe all three channels; watchdog on lack of progress
   always @(posedge clock) begin
      if (!reset) begin
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (csr_valid && csr_ready) sb.write_threshold(csr_data);
         if (req_tvalid && req_tready)
            sb.note_tick(req_tdata[PERIOD_W-1:0], req_tdata[PERIOD_W+TIME_W-1:PERIOD_W]);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_tick(input logic [PERIOD_W-1:0] period,
                            input logic [TIME_W-1:0] stamp);
      int unsigned gap;
      gap = (req_steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({stamp, period});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [PERIOD_W-1:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_thr = value;
   endtask

   task automatic run_phase(input int unsigned count);
      int unsigned sent;
      int unsigned r;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 49) == 0) begin
            req_steady = ($urandom_range(0, 3) == 0);
            rsp_steady = ($urandom_range(0, 3) == 0);
         end
         r = $urandom_range(0, 99);
         if (r < 75) begin
            now_us += ($urandom_range(0, 9) < 7) ? TIME_W'($urandom_range(0, 2))
                                                 : pick_delta();
            send_tick(period_above(), now_us);
            now_us += pick_delta();
            send_tick(period_below(), now_us);
            sent += 2;
         end else if (r < 88) begin
            send_tick(PERIOD_W'($urandom_range(0, 'hFFFFF)), $urandom());
            sent++;
         end else if (r < 94) begin
            now_us += pick_delta();
            send_tick(period_below(), now_us);
            sent++;
         end else begin
            now_us += pick_delta();
            send_tick(period_above(), now_us);
            sent++;
         end
      end
   endtask

   initial begin
      logic [TIME_W-1:0]   t;
      logic [PERIOD_W-1:0] thr_list [6];
      int unsigned         len_list [6];
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      req_steady  = 1'b0;
      rsp_steady  = 1'b0;
      cur_thr     = THRESHOLD_RESET;
      thr_list = '{20'd0, 20'd1000000, PERIOD_ALL_ONES, 20'd0, 20'd1, THRESHOLD_RESET};
      thr_list[3] = PERIOD_W'($urandom_range(1, 'hFFFFE));
      len_list = '{300, 300, 60, 300, 300, 300};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // edge cases at the reset threshold
      send_tick('0, '0);
      send_tick(PERIOD_ALL_ONES, 32'hFFFF_FFFF);
      send_tick(THRESHOLD_RESET, 32'hFFFF_FFFF);
      send_tick(THRESHOLD_RESET + 1'b1, '0);
      send_tick(THRESHOLD_RESET, 32'hFFFF_FFFF);
      send_tick(20'd1000000, 32'd3);
      send_tick('0, 32'd2);
      send_tick(PERIOD_ALL_ONES, 32'd6);
      send_tick('0, 32'd6);
      send_tick(PERIOD_ALL_ONES, 32'd6);
      send_tick('0, 32'd60000006);
      send_tick('0, 32'd60000100);
      send_tick(THRESHOLD_RESET + 1'b1, 32'd60060000);
      send_tick(THRESHOLD_RESET, 32'd60060006);
      t = 32'd60060006;
      for (int i = 0; i < 5; i++) begin
         send_tick(THRESHOLD_RESET + 1'b1, t);
         send_tick(THRESHOLD_RESET, t + 1);
         t = t + 1;
      end
      now_us = t;

      run_phase(300);
      for (int p = 0; p < 6; p++) begin
         write_threshold(thr_list[p]);
         run_phase(len_list[p]);
      end

      drain();
      repeat (80) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
